/* rtl/lgd_pkg.sv */
package lgd_pkg;

   localparam int IDX_W     = 18;
   localparam int OP_W      = 2;
   localparam int DIR_W     = 3;
   localparam int DRAW_W    = 16;
   localparam int THR_W     = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_STEP  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [DIR_W-1:0] DIR_XM = 3'd0;
   localparam logic [DIR_W-1:0] DIR_XP = 3'd1;
   localparam logic [DIR_W-1:0] DIR_YM = 3'd2;
   localparam logic [DIR_W-1:0] DIR_YP = 3'd3;
   localparam logic [DIR_W-1:0] DIR_ZM = 3'd4;
   localparam logic [DIR_W-1:0] DIR_ZP = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_DEATH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH = 2'd1;

   localparam logic [THR_W-1:0] DEATH_RESET = 17'd32768;
   localparam logic [THR_W-1:0] BIRTH_RESET = 17'd65536;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic nb_sel;
      logic mem_we;
      logic mem_wdata;
      logic rsp_load;
      logic rsp_cell;
      logic rsp_changed;
      logic rsp_nb;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic            in_range;
      logic [OP_W-1:0] op;
      logic            write_value;
      logic            rd_bit;
      logic            kill;
      logic            grow;
      logic            dir_valid;
   } dp_status_type;

endpackage

/* rtl/lgd_csr.sv */
module lgd_csr import lgd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_data,
   output logic [THR_W-1:0]     death_threshold,
   output logic [THR_W-1:0]     birth_threshold
);

   logic [THR_W-1:0] death_ff, death_in;
   logic [THR_W-1:0] birth_ff, birth_in;

   assign csr_ready = 1'b1;

   always_comb begin
      death_in = death_ff;
      birth_in = birth_ff;
      if (csr_valid) begin
         // drop writes to unknown indexes
         if (csr_index == CSR_DEATH) death_in = csr_data;
         if (csr_index == CSR_BIRTH) birth_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         death_ff <= DEATH_RESET;
         birth_ff <= BIRTH_RESET;
      end else begin
         death_ff <= death_in;
         birth_ff <= birth_in;
      end
   end

   assign death_threshold = death_ff;
   assign birth_threshold = birth_ff;

endmodule

/* rtl/lgd_ctrl.sv */
module lgd_ctrl import lgd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SITE  = 6'b000010,
      ST_EVAL  = 6'b000100,
      ST_COORD = 6'b001000,
      ST_NREAD = 6'b010000,
      ST_NEVAL = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      nb_live;
   logic      grow_now;

   assign nb_live  = status.rd_bit & status.dir_valid;
   assign grow_now = nb_live & status.grow;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_SITE;
            end
         end
         ST_SITE: begin
            if (!status.in_range) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else if (status.op == OP_WRITE) begin
               cmd.mem_we    = 1'b1;
               cmd.mem_wdata = status.write_value;
               cmd.rsp_load  = 1'b1;
               cmd.rsp_cell  = status.write_value;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.op != OP_STEP) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_cell = status.rd_bit;
               state_in     = ST_IDLE;
            end else if (status.rd_bit) begin
               cmd.mem_we      = status.kill;
               cmd.mem_wdata   = 1'b0;
               cmd.rsp_load    = 1'b1;
               cmd.rsp_cell    = ~status.kill;
               cmd.rsp_changed = status.kill;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_COORD;
            end
         end
         ST_COORD: begin
            state_in = ST_NREAD;
         end
         ST_NREAD: begin
            cmd.nb_sel = 1'b1;
            state_in   = ST_NEVAL;
         end
         ST_NEVAL: begin
            cmd.mem_we      = grow_now;
            cmd.mem_wdata   = 1'b1;
            cmd.rsp_load    = 1'b1;
            cmd.rsp_cell    = grow_now;
            cmd.rsp_changed = grow_now;
            cmd.rsp_nb      = nb_live;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/lgd_dpath.sv */
module lgd_dpath import lgd_pkg::*; #(
   parameter int SIDE = 64
) (
   input  logic              clock,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [IDX_W-1:0]  req_site_index,
   input  logic [DIR_W-1:0]  req_direction,
   input  logic [DRAW_W-1:0] req_random_draw,
   input  logic              req_write_value,
   input  logic [THR_W-1:0]  death_threshold,
   input  logic [THR_W-1:0]  birth_threshold,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   output logic              rsp_cell_value,
   output logic              rsp_changed,
   output logic              rsp_neighbour_occupied
);

   localparam longint CELLS   = longint'(SIDE) * longint'(SIDE) * longint'(SIDE);
   localparam int     ADDR_W  = $clog2(CELLS);
   localparam int     SHIFT   = IDX_W + $clog2(SIDE);
   localparam int     RECIP_W = IDX_W + 2;
   localparam int     PROD_W  = IDX_W + RECIP_W;
   // ceil(2^SHIFT / SIDE): exact quotient for any index below 2^IDX_W
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(SIDE) - 64'd1) / 64'(SIDE));
   localparam logic [IDX_W-1:0]  SIDE_V   = IDX_W'(SIDE);
   localparam logic [IDX_W-1:0]  SIDE_MAX = IDX_W'(SIDE - 1);
   localparam logic [ADDR_W-1:0] STEP_X      = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] WRAP_X      = ADDR_W'(SIDE - 1);
   localparam logic [ADDR_W-1:0] STEP_Y      = ADDR_W'(SIDE);
   localparam logic [ADDR_W-1:0] WRAP_Y      = ADDR_W'(longint'(SIDE) * (SIDE - 1));
   localparam logic [ADDR_W-1:0] STEP_Z      = ADDR_W'(longint'(SIDE) * SIDE);
   localparam logic [ADDR_W-1:0] WRAP_Z      =
      ADDR_W'(longint'(SIDE) * SIDE * (SIDE - 1));

   // latched transaction
   logic [OP_W-1:0]   op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DIR_W-1:0]  dir_ff;
   logic [DRAW_W-1:0] draw_ff;
   logic              wv_ff;
   logic              in_range_ff;

   // coordinate split
   logic [PROD_W-1:0] p1_ff, p1_in;
   logic [PROD_W-1:0] p2_ff, p2_in;
   logic [IDX_W-1:0]  q1_ff, q1_in;
   logic [IDX_W-1:0]  x_full, y_full, z_in;
   logic              x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic              y_lo_ff, y_lo_in, y_hi_ff, y_hi_in;
   logic              z_lo_ff, z_lo_in, z_hi_ff, z_hi_in;

   logic [ADDR_W-1:0] site_addr, nb_addr, mem_addr;
   logic              cells_ff [0:CELLS-1];
   logic              rdata_ff;

   logic rsp_cell_ff, rsp_changed_ff, rsp_nb_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff       <= req_operation;
         idx_ff      <= req_site_index;
         dir_ff      <= req_direction;
         draw_ff     <= req_random_draw;
         wv_ff       <= req_write_value;
         in_range_ff <= (64'(req_site_index) < CELLS);
      end
   end

   // x from idx / SIDE, then y and z from the quotient, one reciprocal step each
   always_comb begin
      p1_in   = PROD_W'(idx_ff) * PROD_W'(RECIP);
      q1_in   = IDX_W'(p1_ff >> SHIFT);
      x_full  = idx_ff - q1_in * SIDE_V;
      x_lo_in = (x_full == '0);
      x_hi_in = (x_full == SIDE_MAX);
      p2_in   = PROD_W'(q1_in) * PROD_W'(RECIP);
      z_in    = IDX_W'(p2_ff >> SHIFT);
      y_full  = q1_ff - z_in * SIDE_V;
      y_lo_in = (y_full == '0);
      y_hi_in = (y_full == SIDE_MAX);
      z_lo_in = (z_in == '0);
      z_hi_in = (z_in == SIDE_MAX);
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      q1_ff   <= q1_in;
      p2_ff   <= p2_in;
      x_lo_ff <= x_lo_in;
      x_hi_ff <= x_hi_in;
      y_lo_ff <= y_lo_in;
      y_hi_ff <= y_hi_in;
      z_lo_ff <= z_lo_in;
      z_hi_ff <= z_hi_in;
   end

   assign site_addr = ADDR_W'(idx_ff);

   always_comb begin
      unique case (dir_ff)
         DIR_XM:  nb_addr = x_lo_ff ? site_addr + WRAP_X : site_addr - STEP_X;
         DIR_XP:  nb_addr = x_hi_ff ? site_addr - WRAP_X : site_addr + STEP_X;
         DIR_YM:  nb_addr = y_lo_ff ? site_addr + WRAP_Y : site_addr - STEP_Y;
         DIR_YP:  nb_addr = y_hi_ff ? site_addr - WRAP_Y : site_addr + STEP_Y;
         DIR_ZM:  nb_addr = z_lo_ff ? site_addr + WRAP_Z : site_addr - STEP_Z;
         DIR_ZP:  nb_addr = z_hi_ff ? site_addr - WRAP_Z : site_addr + STEP_Z;
         default: nb_addr = site_addr;
      endcase
   end

   assign mem_addr = cmd.nb_sel ? nb_addr : site_addr;

   always_ff @(posedge clock) begin
      if (cmd.mem_we) cells_ff[mem_addr] <= cmd.mem_wdata;
      rdata_ff <= cells_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_cell_ff    <= cmd.rsp_cell;
         rsp_changed_ff <= cmd.rsp_changed;
         rsp_nb_ff      <= cmd.rsp_nb;
      end
   end

   always_comb begin
      status.in_range    = in_range_ff;
      status.op          = op_ff;
      status.write_value = wv_ff;
      status.rd_bit      = rdata_ff;
      status.kill        = ({1'b0, draw_ff} < death_threshold);
      status.grow        = ({1'b0, draw_ff} < birth_threshold);
      status.dir_valid   = (dir_ff <= DIR_ZP);
   end

   assign rsp_cell_value         = rsp_cell_ff;
   assign rsp_changed            = rsp_changed_ff;
   assign rsp_neighbour_occupied = rsp_nb_ff;

endmodule

/* rtl/lattice_growth_decay_step_core.sv */
// channel   handshake             payload
// -------   --------------------  ------------------------------------------------
// request   start / busy          req_operation, req_site_index, req_direction,
//                                 req_random_draw, req_write_value
// response  rsp_valid (strobe)    rsp_cell_value, rsp_changed, rsp_neighbour_occupied
// csr       csr_valid / csr_ready csr_index, csr_data
//
// A transaction holds the block through ST_SITE (write, or out-of-range index),
// then ST_EVAL (read, or step of an occupied site), or then ST_EVAL, ST_COORD,
// ST_NREAD and ST_NEVAL (step of an empty site). The single lattice memory port
// and the two reciprocal-multiply stages that split the index set these sequences.
// The next start is taken in the cycle the strobe is shown; rsp_valid lasts one
// cycle and cannot be stalled. Synchronous reset restores the thresholds and
// idles the controller; lattice contents are undefined until written.
module lattice_growth_decay_step_core import lgd_pkg::*; #(
   parameter int SIDE = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [IDX_W-1:0]     req_site_index,
   input  logic [DIR_W-1:0]     req_direction,
   input  logic [DRAW_W-1:0]    req_random_draw,
   input  logic                 req_write_value,
   output logic                 rsp_valid,
   output logic                 rsp_cell_value,
   output logic                 rsp_changed,
   output logic                 rsp_neighbour_occupied,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_data
);

   logic [THR_W-1:0] death_threshold;
   logic [THR_W-1:0] birth_threshold;
   ctrl_cmd_type     cmd;
   dp_status_type    status;

   lgd_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .death_threshold (death_threshold),
      .birth_threshold (birth_threshold)
   );

   lgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   lgd_dpath #(
      .SIDE (SIDE)
   ) u_dpath (
      .clock                  (clock),
      .req_operation          (req_operation),
      .req_site_index         (req_site_index),
      .req_direction          (req_direction),
      .req_random_draw        (req_random_draw),
      .req_write_value        (req_write_value),
      .death_threshold        (death_threshold),
      .birth_threshold        (birth_threshold),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_cell_value         (rsp_cell_value),
      .rsp_changed            (rsp_changed),
      .rsp_neighbour_occupied (rsp_neighbour_occupied)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a transaction in flight");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_growth_needs_nb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_changed && rsp_cell_value) |-> rsp_neighbour_occupied)
      else $error("site filled without an occupied neighbour");

endmodule
